// ===== rtl/homogeneous_point_transform_assert.svh =====
// ----------------------------------------------------------------------------
// homogeneous_point_transform_assert
// Assertion helpers for the point transform RTL.
// ----------------------------------------------------------------------------
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HPT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define HPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hpt_pkg.sv =====
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared widths, register map, stage plan and helpers for the transform.
// ----------------------------------------------------------------------------
`default_nettype none

package hpt_pkg;

    localparam int CW    = 32;          // coordinate / coefficient width
    localparam int FB    = 16;          // fraction bits
    localparam int SW    = 2 * CW + 2;  // exact signed row sum
    localparam int MW    = SW - 1;      // row sum magnitude
    localparam int NW    = MW + FB;     // dividend width
    localparam int QW    = CW;          // quotient bits produced
    localparam int NREG  = 8;
    localparam int IW    = $clog2(NREG);
    localparam int RW    = 2 * CW;      // config register width
    localparam int NPRE  = 4;           // product, pair, row sum, prep
    localparam int NDIV  = QW + 1;      // overflow check + quotient steps
    localparam int NST   = NPRE + NDIV + 1;
    localparam int ST_OUT = NST - 1;

    typedef enum logic [IW-1:0] {
        REG_ROW0_LEFT, REG_ROW0_RIGHT, REG_ROW1_LEFT, REG_ROW1_RIGHT,
        REG_ROW2_LEFT, REG_ROW2_RIGHT, REG_ROW3_LEFT, REG_ROW3_RIGHT
    } reg_idx_t;

    localparam logic [RW-1:0] ONE_Q = RW'(1) << FB;

    localparam logic [RW-1:0] CFG_RESET [NREG] = '{
        ONE_Q << CW, '0, ONE_Q, '0, '0, ONE_Q << CW, '0, ONE_Q
    };

    typedef struct packed {
        logic [NW-1:0] n;
        logic [MW-1:0] d;
        logic          neg;
        logic          tag;
    } lane_in_t;

    typedef struct packed {
        logic [QW-1:0] q;
        logic          ovf;
        logic          neg;
        logic          tag;
    } lane_out_t;

    // returns {clamped, value}
    function automatic logic [CW:0] clamp_q(input lane_out_t r);
        logic          big;
        logic [CW-1:0] val;
        if (r.neg)
        begin
            big = r.ovf || (r.q > (QW'(1) << (CW - 1)));
            val = big ? (CW'(1) << (CW - 1)) : CW'(-r.q);
        end
        else
        begin
            big = r.ovf || r.q[QW-1];
            val = big ? ((CW'(1) << (CW - 1)) - CW'(1)) : CW'(r.q);
        end
        return {big, val};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// hpt_ctrl
// Per-stage valid bits and advance enables; bubbles collapse under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_ctrl
    import hpt_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           out_ready,
    output logic [NST-1:0]      adv,
    output logic                out_valid
);

    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;

    // stage k may load when the last stage drains or any stage at/after k is empty
    always_comb
    begin
        for (int k = 0; k < NST; k++)
        begin
            adv[k] = out_ready || ((v_reg | ((NST'(1) << k) - NST'(1))) != '1);
        end
        v_next[0] = adv[0] ? in_valid : v_reg[0];
        for (int k = 1; k < NST; k++)
        begin
            if (!adv[k])
                v_next[k] = v_reg[k];
            else
                v_next[k] = v_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign out_valid = v_reg[NST-1];

endmodule

`default_nettype wire

// ===== rtl/hpt_mac.sv =====
// ----------------------------------------------------------------------------
// hpt_mac
// Matrix products, row sums and divider operand preparation (4 stages).
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_mac
    import hpt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic [NPRE-1:0]      adv,
    input  wire logic [CW-1:0]        x_in,
    input  wire logic [CW-1:0]        y_in,
    input  wire logic [CW-1:0]        z_in,
    input  wire logic                 is_direction,
    input  wire logic [15:0][CW-1:0]  coef,
    output lane_in_t [2:0]            lanes
);

    logic signed [2*CW-1:0] prod_reg [4][4];
    logic signed [2*CW:0]   pair_reg [4][2];
    logic signed [SW-1:0]   sum_reg  [4];
    logic                   dir_reg  [3];
    lane_in_t [2:0]         lane_reg;

    logic signed [CW-1:0]   xs, ys, zs;
    assign xs = x_in;
    assign ys = y_in;
    assign zs = z_in;

    // stage 0: twelve products plus translation terms scaled to 2F fraction bits
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int r = 0; r < 4; r++)
            begin
                prod_reg[r][0] <= $signed(coef[r*4+0]) * xs;
                prod_reg[r][1] <= $signed(coef[r*4+1]) * ys;
                prod_reg[r][2] <= $signed(coef[r*4+2]) * zs;
                prod_reg[r][3] <= {{(CW-FB){coef[r*4+3][CW-1]}}, coef[r*4+3], {FB{1'b0}}};
            end
            dir_reg[0] <= is_direction;
        end
    end

    // stage 1: pair sums; translation dropped for directions on rows 0..2
    logic signed [2*CW-1:0] tr [4];
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            tr[r] = prod_reg[r][3];
            if (dir_reg[0] && r < 3)
                tr[r] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int r = 0; r < 4; r++)
            begin
                pair_reg[r][0] <= (2*CW+1)'(prod_reg[r][0]) + (2*CW+1)'(prod_reg[r][1]);
                pair_reg[r][1] <= (2*CW+1)'(prod_reg[r][2]) + (2*CW+1)'(tr[r]);
            end
            dir_reg[1] <= dir_reg[0];
        end
    end

    // stage 2: full row sums
    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int r = 0; r < 4; r++)
                sum_reg[r] <= SW'(pair_reg[r][0]) + SW'(pair_reg[r][1]);
            dir_reg[2] <= dir_reg[1];
        end
    end

    // stage 3: sign/magnitude split and divider operands
    logic [SW-1:0] abs_v [4];
    logic          neg_v [4];
    logic          w_zero;
    lane_in_t [2:0] lane_next;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            neg_v[r] = sum_reg[r][SW-1];
            abs_v[r] = neg_v[r] ? SW'(-sum_reg[r]) : SW'(sum_reg[r]);
        end
        w_zero = !dir_reg[2] && (sum_reg[3] == '0);
        for (int k = 0; k < 3; k++)
        begin
            if (dir_reg[2])
            begin
                // truncating shift by F expressed as a divide by 2^F
                lane_next[k].n   = NW'(abs_v[k][MW-1:0]);
                lane_next[k].d   = MW'(1) << FB;
                lane_next[k].neg = neg_v[k];
            end
            else
            begin
                lane_next[k].n   = {abs_v[k][MW-1:0], {FB{1'b0}}};
                lane_next[k].d   = abs_v[3][MW-1:0];
                lane_next[k].neg = neg_v[k] ^ neg_v[3];
            end
            lane_next[k].tag = (k == 0) ? w_zero : 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
            lane_reg <= lane_next;
    end

    assign lanes = lane_reg;

endmodule

`default_nettype wire

// ===== rtl/hpt_div_lane.sv =====
// ----------------------------------------------------------------------------
// hpt_div_lane
// Pipelined restoring divider: overflow check, then one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_div_lane
    import hpt_pkg::*;
(
    input  wire logic            clk,
    input  wire logic [NDIV-1:0] adv,
    input  wire lane_in_t        din,
    output lane_out_t            dout
);

    logic [MW-1:0] r_reg   [NDIV];
    logic [MW-1:0] d_reg   [NDIV];
    logic [QW-1:0] n_reg   [NDIV];
    logic [QW-1:0] q_reg   [NDIV];
    logic          ovf_reg [NDIV];
    logic          neg_reg [NDIV];
    logic          tag_reg [NDIV];

    // head: quotient >= 2^QW exactly when the upper dividend part reaches d
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            r_reg[0]   <= MW'(din.n[NW-1:QW]);
            d_reg[0]   <= din.d;
            n_reg[0]   <= din.n[QW-1:0];
            q_reg[0]   <= '0;
            ovf_reg[0] <= MW'(din.n[NW-1:QW]) >= din.d;
            neg_reg[0] <= din.neg;
            tag_reg[0] <= din.tag;
        end
    end

    for (genvar s = 1; s < NDIV; s++)
    begin : g_step
        logic [MW:0] trial;
        logic        ge;
        assign trial = {r_reg[s-1], n_reg[s-1][QW-1]};
        assign ge    = trial >= {1'b0, d_reg[s-1]};

        always_ff @(posedge clk)
        begin
            if (adv[s])
            begin
                r_reg[s]   <= ge ? MW'(trial - {1'b0, d_reg[s-1]}) : MW'(trial);
                d_reg[s]   <= d_reg[s-1];
                n_reg[s]   <= {n_reg[s-1][QW-2:0], 1'b0};
                q_reg[s]   <= {q_reg[s-1][QW-2:0], ge};
                ovf_reg[s] <= ovf_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    assign dout.q   = q_reg[NDIV-1];
    assign dout.ovf = ovf_reg[NDIV-1];
    assign dout.neg = neg_reg[NDIV-1];
    assign dout.tag = tag_reg[NDIV-1];

endmodule

`default_nettype wire

// ===== rtl/homogeneous_point_transform.sv =====
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 homogeneous transform of Q16.16 points/directions, one item per clock while m_tready is high.
// ----------------------------------------------------------------------------
//  channel  signals                           payload (low bit first)
//  s_axis   s_tvalid s_tready s_tdata s_tuser x_in, y_in, z_in | is_direction
//  m_axis   m_tvalid m_tready m_tdata m_tuser x_out, y_out, z_out | w_zero, saturated
//  cfg      cfg_valid cfg_ready cfg_index/data  row register 0..7, 64-bit value
//
//  38 register stages; throughput one request per clock while m_tready is high.
//  The depth is set by the restoring divider: one overflow check plus 32 quotient
//  stages per lane. rst_n clears valid bits and loads the identity matrix;
//  datapath is not reset. A stalled output fills empty stages first; s_tready
//  drops only when every stage holds a request. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module homogeneous_point_transform
    import hpt_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [3*CW-1:0] s_tdata,    // x_in, y_in, z_in
    input  wire logic            s_tuser,    // is_direction
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [3*CW-1:0]      m_tdata,    // x_out, y_out, z_out
    output logic [1:0]           m_tuser,    // w_zero, saturated
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [IW-1:0]   cfg_index,
    input  wire logic [RW-1:0]   cfg_data
);

`include "homogeneous_point_transform_assert.svh"

    // matrix registers, identity after reset
    logic [RW-1:0] cfg_reg [NREG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREG; i++)
                cfg_reg[i] <= CFG_RESET[i];
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // left register: first coefficient high, second low; same for right
    logic [15:0][CW-1:0] coef;
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            coef[r*4+0] = cfg_reg[2*r][RW-1:CW];
            coef[r*4+1] = cfg_reg[2*r][CW-1:0];
            coef[r*4+2] = cfg_reg[2*r+1][RW-1:CW];
            coef[r*4+3] = cfg_reg[2*r+1][CW-1:0];
        end
    end

    // pipeline flow control
    logic [NST-1:0] adv;

    hpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .adv       (adv),
        .out_valid (m_tvalid)
    );

    assign s_tready = adv[0];

    // products, sums, operand prep
    lane_in_t [2:0] lanes;

    hpt_mac u_mac (
        .clk          (clk),
        .adv          (adv[NPRE-1:0]),
        .x_in         (s_tdata[CW-1:0]),
        .y_in         (s_tdata[2*CW-1:CW]),
        .z_in         (s_tdata[3*CW-1:2*CW]),
        .is_direction (s_tuser),
        .coef         (coef),
        .lanes        (lanes)
    );

    // one divider per coordinate; lane 0 carries the zero-w mark along
    lane_out_t [2:0] quo;

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        hpt_div_lane u_div (
            .clk  (clk),
            .adv  (adv[NPRE+NDIV-1:NPRE]),
            .din  (lanes[k]),
            .dout (quo[k])
        );
    end

    // output stage: clamp to the coordinate range and pack
    logic [3*CW-1:0] data_reg;
    logic [1:0]      user_reg;
    logic [3*CW-1:0] data_next;
    logic [2:0]      clip;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            {clip[k], data_next[k*CW +: CW]} = clamp_q(quo[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_OUT])
        begin
            data_reg <= data_next;
            user_reg <= {|clip, quo[0].tag};
        end
    end

    assign m_tdata = data_reg;
    assign m_tuser = user_reg;

    // x sits at one of the two range limits
    logic x_at_limit;
    assign x_at_limit = (m_tdata[CW-1:0] == {1'b0, {(CW-1){1'b1}}}) ||
                        (m_tdata[CW-1:0] == {1'b1, {(CW-1){1'b0}}});

    // zero w always forces a clamp
    `HPT_ASSERT_SAME(a_wz_sat, m_tvalid && m_tuser[0], m_tuser[1], "w_zero without saturated")
    // zero w yields range limits on x
    `HPT_ASSERT_SAME(a_wz_lim, m_tvalid && m_tuser[0], x_at_limit, "w_zero x not at limit")
    // an empty output stage never back-pressures the input
    `HPT_ASSERT_SAME(a_rdy, !m_tvalid, s_tready, "input stalled with empty output")
    // a waiting result stays put
    `HPT_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")

endmodule

`default_nettype wire
